FILE: design/uer_pkg.sv
// uer_pkg: shared types and constants of the ultrasonic echo ranger.
// Field widths, action, status and register codes. No dependencies.
package uer_pkg;

	localparam int ACTION_W   = 2;
	localparam int INDEX_W    = 3;
	localparam int LINES_W    = 4;
	localparam int SENSOR_W   = 2;
	localparam int DIST_W     = 11;
	localparam int STATUS_W   = 2;
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 16;
	localparam int TICKS_W    = 16;
	localparam int SUB_W      = 6;

	typedef logic [ACTION_W-1:0]   action_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [REG_IDX_W-1:0]  reg_idx_t;

	// request codes carried by a tick
	localparam action_t ACT_TICK    = 2'd0;
	localparam action_t ACT_MEASURE = 2'd1;
	localparam action_t ACT_SWEEP   = 2'd2;

	// report status codes
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_NO_RISE   = 2'd1;
	localparam status_t STATUS_TOO_LONG  = 2'd2;
	localparam status_t STATUS_BAD_INDEX = 2'd3;

	// configuration register indexes
	localparam reg_idx_t REG_TIMEOUT = 2'd0;
	localparam reg_idx_t REG_PULSE   = 2'd1;
	localparam reg_idx_t REG_SETTLE  = 2'd2;
	localparam reg_idx_t REG_GAP     = 2'd3;

	// register reset values
	localparam logic [15:0] TIMEOUT_RST = 16'd26000;
	localparam logic [7:0]  PULSE_RST   = 8'd10;
	localparam logic [7:0]  SETTLE_RST  = 8'd2;
	localparam logic [15:0] GAP_RST     = 16'd10000;

	// echo ticks per centimeter and distance saturation
	localparam logic [SUB_W-1:0]  TICKS_PER_CM = 6'd58;
	localparam logic [DIST_W-1:0] CM_MAX       = 11'd2047;

endpackage

FILE: design/uer_channels.sv
// uer_channels: valid/ready channel interfaces of the echo ranger
// (tick input, result output, register write). Depends on uer_pkg.
interface uer_tick_if;
	logic                          valid;
	logic                          ready;
	logic [uer_pkg::ACTION_W-1:0]  action;
	logic [uer_pkg::INDEX_W-1:0]   sensor_index;
	logic [uer_pkg::LINES_W-1:0]   echo_lines;

	modport source (output valid, output action, output sensor_index, output echo_lines,
		input ready);
	modport sink (input valid, input action, input sensor_index, input echo_lines,
		output ready);
endinterface

interface uer_result_if;
	logic                          valid;
	logic                          ready;
	logic [uer_pkg::LINES_W-1:0]   trig_lines;
	logic                          busy_res;
	logic                          result_valid;
	logic [uer_pkg::SENSOR_W-1:0]  sensor_id;
	logic [uer_pkg::DIST_W-1:0]    distance_cm;
	logic [uer_pkg::STATUS_W-1:0]  status;
	logic                          last_of_run;

	modport source (output valid, output trig_lines, output busy_res, output result_valid,
		output sensor_id, output distance_cm, output status, output last_of_run,
		input ready);
	modport sink (input valid, input trig_lines, input busy_res, input result_valid,
		input sensor_id, input distance_cm, input status, input last_of_run,
		output ready);
endinterface

interface uer_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [uer_pkg::REG_IDX_W-1:0]   index;
	logic [uer_pkg::REG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/ultrasonic_echo_ranger.sv
// ultrasonic_echo_ranger: controller for up to four ultrasonic rangers.
// Depends on uer_pkg and the channel interfaces in uer_channels.sv.
//
// Each tick transaction is one microsecond of the timebase and yields exactly one
// result transaction. It takes one tick every clock cycle as long as the result side
// keeps up: the phase state and counters advance in a single pass of logic from the
// state registers and the incoming tick into the result register, and a new tick is
// taken whenever that register is empty or is being drained in the same cycle; the
// result of a tick is registered and shown in the cycle after that tick is taken.
// A measure request (one sensor) or sweep request (sensors 0 upward) is taken only
// while idle; otherwise it is ignored. Every measurement runs settle (trigger low),
// pulse (trigger high), wait for echo rise, high count if it rises, then a guard gap.
// Distance comes from a 58-tick sub-counter, no divider. Timeouts report status
// 1 or 2 with zero distance; an out-of-range index gives one bad-index report.
// Register writes are always accepted and take effect on the next tick.
// SENSOR_COUNT (1 or more) limits valid indexes and sweep length, capped at four sensors.
module ultrasonic_echo_ranger #(
	parameter int SENSOR_COUNT = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	uer_tick_if.sink        tick,
	uer_result_if.source    result,
	uer_cfg_if.sink         cfg
);

	// phase codes
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SETTLE = 3'd1;
	localparam logic [2:0] PH_PULSE  = 3'd2;
	localparam logic [2:0] PH_RISE   = 3'd3;
	localparam logic [2:0] PH_HIGH   = 3'd4;
	localparam logic [2:0] PH_GAP    = 3'd5;

	localparam int SENSORS_USED = (SENSOR_COUNT < 4) ? SENSOR_COUNT : 4;
	localparam logic [uer_pkg::SENSOR_W-1:0] LAST_SENSOR =
		uer_pkg::SENSOR_W'(SENSORS_USED - 1);
	localparam logic [uer_pkg::INDEX_W-1:0] MAX_INDEX =
		uer_pkg::INDEX_W'(SENSORS_USED - 1);

	// configuration registers
	logic [15:0] timeout_q;
	logic [7:0]  pulse_q;
	logic [7:0]  settle_q;
	logic [15:0] gap_q;

	// sequencer state
	logic [2:0]                      phase_q;
	logic [uer_pkg::TICKS_W-1:0]     ticks_q;
	logic [uer_pkg::DIST_W-1:0]      cm_q;
	logic [uer_pkg::SUB_W-1:0]       sub_q;
	logic [uer_pkg::SENSOR_W-1:0]    sensor_q;
	logic                            sweep_q;

	// result register
	logic                            out_valid_q;
	logic [uer_pkg::LINES_W-1:0]     trig_q;
	logic                            busy_q;
	logic                            rvalid_q;
	logic [uer_pkg::SENSOR_W-1:0]    sid_q;
	logic [uer_pkg::DIST_W-1:0]      dist_q;
	uer_pkg::status_t                status_q;
	logic                            last_q;

	// next-state values
	logic [2:0]                      ph;
	logic [uer_pkg::TICKS_W-1:0]     tk;
	logic [uer_pkg::DIST_W-1:0]      cm;
	logic [uer_pkg::SUB_W-1:0]       sub;
	logic [uer_pkg::SUB_W-1:0]       sub_inc;
	logic [uer_pkg::SENSOR_W-1:0]    cs;
	logic                            sw;
	logic                            go;
	logic                            lvl;
	logic [uer_pkg::LINES_W-1:0]     trig;
	logic                            vld;
	logic [uer_pkg::SENSOR_W-1:0]    sid;
	logic [uer_pkg::DIST_W-1:0]      dist_cm;
	uer_pkg::status_t                st;
	logic                            last;

	logic tick_take;

	assign tick.ready = !out_valid_q || result.ready;
	assign tick_take  = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	// One tick of the sequencer. Several phases may pass in one tick: gap into
	// settle at the start of a sweep's next sensor, settle into pulse
	// for a zero settle time, and echo rise straight into the high count.
	always_comb begin
		ph   = phase_q;
		tk   = ticks_q;
		cm   = cm_q;
		sub  = sub_q;
		cs   = sensor_q;
		sw   = sweep_q;
		go   = 1'b1;
		lvl  = 1'b0;
		sub_inc = '0;
		trig = '0;
		vld  = 1'b0;
		sid  = '0;
		dist_cm = '0;
		st   = uer_pkg::STATUS_OK;
		last = 1'b0;

		// requests only while idle
		if (ph == PH_IDLE) begin
			if (tick.action == uer_pkg::ACT_MEASURE) begin
				if (tick.sensor_index > MAX_INDEX) begin
					vld  = 1'b1;
					st   = uer_pkg::STATUS_BAD_INDEX;
					last = 1'b1;
				end else begin
					cs = tick.sensor_index[uer_pkg::SENSOR_W-1:0];
					sw = 1'b0;
					ph = PH_SETTLE;
					tk = '0;
				end
			end else if (tick.action == uer_pkg::ACT_SWEEP) begin
				cs = '0;
				sw = 1'b1;
				ph = PH_SETTLE;
				tk = '0;
			end
		end

		// guard gap, then idle or the next sensor of a sweep
		if (ph == PH_GAP) begin
			if (tk < gap_q) begin
				tk = tk + 1'b1;
				go = 1'b0;
			end else if (sw && cs < LAST_SENSOR) begin
				cs = cs + 1'b1;
				ph = PH_SETTLE;
				tk = '0;
			end else begin
				ph = PH_IDLE;
				tk = '0;
				sw = 1'b0;
				go = 1'b0;
			end
		end

		// trigger held low
		if (go && ph == PH_SETTLE) begin
			if (tk < {8'd0, settle_q}) begin
				tk = tk + 1'b1;
				go = 1'b0;
			end else begin
				ph = PH_PULSE;
				tk = '0;
			end
		end

		// trigger pulse; the move to the rise wait ends the tick
		if (go && ph == PH_PULSE) begin
			if (tk < {8'd0, pulse_q}) begin
				tk   = tk + 1'b1;
				trig = uer_pkg::LINES_W'(1) << cs;
			end else begin
				ph = PH_RISE;
				tk = '0;
			end
			go = 1'b0;
		end

		// wait for echo rise
		if (go && ph == PH_RISE) begin
			lvl = tick.echo_lines[cs];
			if (lvl) begin
				ph  = PH_HIGH;
				tk  = '0;
				cm  = '0;
				sub = '0;
			end else begin
				if (tk >= timeout_q) begin
					vld = 1'b1;
					st  = uer_pkg::STATUS_NO_RISE;
				end else begin
					tk = tk + 1'b1;
				end
				go = 1'b0;
			end
		end

		// echo high count, one centimeter every 58 ticks
		if (go && ph == PH_HIGH) begin
			lvl = tick.echo_lines[cs];
			if (!lvl) begin
				vld     = 1'b1;
				dist_cm = cm;
			end else if (tk >= timeout_q) begin
				vld = 1'b1;
				st  = uer_pkg::STATUS_TOO_LONG;
			end else begin
				tk      = tk + 1'b1;
				sub_inc = sub + 1'b1;
				if (sub_inc >= uer_pkg::TICKS_PER_CM) begin
					sub = '0;
					if (cm < uer_pkg::CM_MAX) begin
						cm = cm + 1'b1;
					end
				end else begin
					sub = sub_inc;
				end
			end
		end

		// unused phase codes fall back to idle
		if (ph > PH_GAP) begin
			ph = PH_IDLE;
		end

		// a measurement report starts the guard gap
		if (vld && ph != PH_IDLE) begin
			sid  = cs;
			last = !sw || cs >= LAST_SENSOR;
			ph   = PH_GAP;
			tk   = '0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= uer_pkg::TIMEOUT_RST;
			pulse_q   <= uer_pkg::PULSE_RST;
			settle_q  <= uer_pkg::SETTLE_RST;
			gap_q     <= uer_pkg::GAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				uer_pkg::REG_TIMEOUT: timeout_q <= cfg.data;
				uer_pkg::REG_PULSE:   pulse_q   <= cfg.data[7:0];
				uer_pkg::REG_SETTLE:  settle_q  <= cfg.data[7:0];
				uer_pkg::REG_GAP:     gap_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// sequencer state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ticks_q  <= '0;
			cm_q     <= '0;
			sub_q    <= '0;
			sensor_q <= '0;
			sweep_q  <= 1'b0;
		end else if (tick_take) begin
			phase_q  <= ph;
			ticks_q  <= tk;
			cm_q     <= cm;
			sub_q    <= sub;
			sensor_q <= cs;
			sweep_q  <= sw;
		end
	end

	// result register: holds a transaction until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			trig_q   <= trig;
			busy_q   <= (ph != PH_IDLE);
			rvalid_q <= vld;
			sid_q    <= sid;
			dist_q   <= dist_cm;
			status_q <= st;
			last_q   <= last;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.trig_lines   = trig_q;
	assign result.busy_res     = busy_q;
	assign result.result_valid = rvalid_q;
	assign result.sensor_id    = sid_q;
	assign result.distance_cm  = dist_q;
	assign result.status       = status_q;
	assign result.last_of_run  = last_q;

endmodule

FILE: design/uer_checker.sv
// uer_checker: port-level assertions for ultrasonic_echo_ranger, bound to it below.
// Depends on uer_pkg.
module uer_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [uer_pkg::LINES_W-1:0]   trig_lines,
	input logic                          busy_res,
	input logic                          result_valid,
	input logic [uer_pkg::SENSOR_W-1:0]  sensor_id,
	input logic [uer_pkg::DIST_W-1:0]    distance_cm,
	input logic [uer_pkg::STATUS_W-1:0]  status,
	input logic                          last_of_run
);

	// a stalled result transaction keeps its trigger lines, report flag, distance and status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(trig_lines) &&
			$stable(result_valid) && $stable(distance_cm) && $stable(status))
		else $error("result payload changed while stalled");

	// no report means all report fields are zero
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_valid |-> status == uer_pkg::STATUS_OK &&
			distance_cm == '0 && sensor_id == '0 && !last_of_run)
		else $error("report fields set without a report");

	// a rejected index ends its run at once with nothing measured
	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_valid && status == uer_pkg::STATUS_BAD_INDEX |->
			sensor_id == '0 && distance_cm == '0 && last_of_run)
		else $error("bad index report malformed");

	// a timeout carries no distance and opens the guard gap
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_valid && (status == uer_pkg::STATUS_NO_RISE ||
			status == uer_pkg::STATUS_TOO_LONG) |-> distance_cm == '0 && busy_res)
		else $error("timeout report malformed");

	// at most one trigger at a time, and only during a measurement
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trig_lines != '0 |-> $onehot(trig_lines) && busy_res && !result_valid)
		else $error("trigger lines malformed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.trig_lines   (result.trig_lines),
	.busy_res     (result.busy_res),
	.result_valid (result.result_valid),
	.sensor_id    (result.sensor_id),
	.distance_cm  (result.distance_cm),
	.status       (result.status),
	.last_of_run  (result.last_of_run)
);

FILE: dv/tb_ultrasonic_echo_ranger.sv
// tb_ultrasonic_echo_ranger: self-checking bench for the four-channel echo ranger.
// Predicts every result transaction from the accepted tick stream; needs uer_pkg,
// the uer_channels interfaces and ultrasonic_echo_ranger.

localparam int RANGER_SENSORS = 4;

// action code 3 has no meaning in the block and acts as a plain tick
localparam uer_pkg::action_t ACT_SPARE = 2'd3;

typedef enum logic [2:0] {
	RG_IDLE, RG_SETTLE, RG_PULSE, RG_RISE, RG_HIGH, RG_GAP
} ranger_phase_t;

typedef struct packed {
	logic [uer_pkg::LINES_W-1:0]  trig;
	logic                         busy;
	logic                         report;
	logic [uer_pkg::SENSOR_W-1:0] sensor;
	logic [uer_pkg::DIST_W-1:0]   cm;
	uer_pkg::status_t             status;
	logic                         last;
} ranger_out_t;

class echo_ranger_scoreboard;
	// timing registers
	logic [15:0] timeout_us;
	logic [7:0]  trig_high;
	logic [7:0]  settle_us;
	logic [15:0] gap_us;
	// measurement state
	ranger_phase_t               phase;
	logic [uer_pkg::TICKS_W-1:0] phase_ticks;
	logic [uer_pkg::DIST_W-1:0]  cm_count;
	logic [uer_pkg::SUB_W-1:0]   sub_cm;
	logic [1:0]                  sensor;
	logic                        sweep;

	ranger_out_t owed[$];
	int errors;

	function new();
		timeout_us = uer_pkg::TIMEOUT_RST;
		trig_high = uer_pkg::PULSE_RST;
		settle_us = uer_pkg::SETTLE_RST;
		gap_us = uer_pkg::GAP_RST;
		phase = RG_IDLE;
		phase_ticks = '0;
		cm_count = '0;
		sub_cm = '0;
		sensor = '0;
		sweep = 1'b0;
		errors = 0;
	endfunction

	function void write_reg(uer_pkg::reg_idx_t idx, logic [15:0] data);
		case (idx)
			uer_pkg::REG_TIMEOUT: timeout_us = data;
			uer_pkg::REG_PULSE:   trig_high = data[7:0];
			uer_pkg::REG_SETTLE:  settle_us = data[7:0];
			uer_pkg::REG_GAP:     gap_us = data;
			default: ;
		endcase
	endfunction

	function bit sensor_last(logic [1:0] s);
		return (int'(s) + 1 >= RANGER_SENSORS) || (s >= 2'd3);
	endfunction

	// one microsecond of the controller; stages of zero length fall through
	function ranger_out_t advance_one_tick(uer_pkg::action_t act, logic [2:0] idx,
			logic [3:0] echo);
		ranger_out_t o;
		logic lvl;
		bit again;
		o = '0;
		again = 1'b1;
		if (phase == RG_IDLE) begin
			if (act == uer_pkg::ACT_MEASURE) begin
				if (int'(idx) >= RANGER_SENSORS || idx > 3'd3) begin
					o.report = 1'b1;
					o.status = uer_pkg::STATUS_BAD_INDEX;
					o.last = 1'b1;
				end else begin
					sensor = idx[1:0];
					sweep = 1'b0;
					phase = RG_SETTLE;
					phase_ticks = '0;
				end
			end else if (act == uer_pkg::ACT_SWEEP) begin
				sensor = '0;
				sweep = 1'b1;
				phase = RG_SETTLE;
				phase_ticks = '0;
			end
		end
		while (again) begin
			lvl = echo[sensor];
			again = 1'b0;
			case (phase)
				RG_SETTLE: begin
					if (phase_ticks < settle_us) begin
						phase_ticks++;
					end else begin
						phase = RG_PULSE;
						phase_ticks = '0;
						again = 1'b1;
					end
				end
				RG_PULSE: begin
					if (phase_ticks < trig_high) begin
						phase_ticks++;
						o.trig = 4'b0001 << sensor;
					end else begin
						phase = RG_RISE;
						phase_ticks = '0;
					end
				end
				RG_RISE: begin
					if (lvl) begin
						phase = RG_HIGH;
						phase_ticks = '0;
						cm_count = '0;
						sub_cm = '0;
						again = 1'b1;
					end else if (phase_ticks >= timeout_us) begin
						o.report = 1'b1;
						o.status = uer_pkg::STATUS_NO_RISE;
					end else begin
						phase_ticks++;
					end
				end
				RG_HIGH: begin
					if (!lvl) begin
						o.report = 1'b1;
						o.cm = cm_count;
					end else if (phase_ticks >= timeout_us) begin
						o.report = 1'b1;
						o.status = uer_pkg::STATUS_TOO_LONG;
					end else begin
						phase_ticks++;
						sub_cm++;
						if (sub_cm >= uer_pkg::TICKS_PER_CM) begin
							sub_cm = '0;
							if (cm_count < uer_pkg::CM_MAX)
								cm_count++;
						end
					end
				end
				RG_GAP: begin
					if (phase_ticks < gap_us) begin
						phase_ticks++;
					end else if (sweep && !sensor_last(sensor)) begin
						sensor++;
						phase = RG_SETTLE;
						phase_ticks = '0;
						again = 1'b1;
					end else begin
						phase = RG_IDLE;
						phase_ticks = '0;
						sweep = 1'b0;
					end
				end
				default: phase = RG_IDLE;
			endcase
			// a report closes the measurement and opens the guard gap
			if (o.report && phase != RG_IDLE) begin
				o.sensor = sensor;
				o.last = !sweep || sensor_last(sensor);
				phase = RG_GAP;
				phase_ticks = '0;
				again = 1'b0;
			end
		end
		o.busy = (phase != RG_IDLE);
		return o;
	endfunction

	function void note_tick(uer_pkg::action_t act, logic [2:0] idx, logic [3:0] echo);
		owed.push_back(advance_one_tick(act, idx, echo));
	endfunction

	function void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t  %s mismatch: expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(ranger_out_t got);
		ranger_out_t want;
		if (owed.size() == 0) begin
			errors++;
			$display("%0t  result with no tick owed: expected none actual %h", $time, got);
			return;
		end
		want = owed.pop_front();
		check_field("trig_lines", 16'(want.trig), 16'(got.trig));
		check_field("busy_res", 16'(want.busy), 16'(got.busy));
		check_field("result_valid", 16'(want.report), 16'(got.report));
		check_field("sensor_id", 16'(want.sensor), 16'(got.sensor));
		check_field("distance_cm", 16'(want.cm), 16'(got.cm));
		check_field("status", 16'(want.status), 16'(got.status));
		check_field("last_of_run", 16'(want.last), 16'(got.last));
	endfunction
endclass

module tb_ultrasonic_echo_ranger;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 64;   // long receiver hold-off, enough to back up the input

	logic clk;
	logic arst_n;

	uer_tick_if   tick_ch();
	uer_result_if res_ch();
	uer_cfg_if    cfg_ch();

	ultrasonic_echo_ranger #(
		.SENSOR_COUNT(RANGER_SENSORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	echo_ranger_scoreboard sb = new();

	bit no_idle;     // last part of the run: both sides at full rate
	int hold_asks;   // each new value asks the result side for one long hold-off
	bit glitches;    // random echo glitches, from the random part on

	// echo shaping for the measured sensor: low ticks before the rise, then high ticks
	int rise_wait;
	int high_left;
	bit armed;

	int ticks_random;

	// ---------------------------------------------------------------- clock, reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL ultrasonic_echo_ranger");
		$finish;
	end

	// ---------------------------------------------------------------- result side
	// Random stall bursts, plus one long hold-off on request. The hold-off is counted
	// here so the sender keeps offering ticks and the block has to push back.
	initial begin
		int hold_seen;
		hold_seen = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// every accepted result transaction is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result('{trig: res_ch.trig_lines, busy: res_ch.busy_res,
				report: res_ch.result_valid, sensor: res_ch.sensor_id,
				cm: res_ch.distance_cm, status: res_ch.status,
				last: res_ch.last_of_run});
	end

	// ---------------------------------------------------------------- tick side
	// Offer one tick and hold it until taken; the prediction is made right at the
	// accepting edge so the next pick already sees the updated phase.
	task automatic offer_tick(uer_pkg::action_t act, logic [2:0] idx, logic [3:0] echo);
		tick_ch.valid <= 1'b1;
		tick_ch.action <= act;
		tick_ch.sensor_index <= idx;
		tick_ch.echo_lines <= echo;
		do @(posedge clk); while (!tick_ch.ready);
		sb.note_tick(act, idx, echo);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// sender pause: nothing offered until every owed result is back
	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(uer_pkg::reg_idx_t idx, logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
	endtask

	// only called with the tick channel drained
	task automatic set_timing(logic [15:0] tmo, logic [7:0] pulse, logic [7:0] settle,
			logic [15:0] gap);
		write_reg(uer_pkg::REG_TIMEOUT, tmo);
		write_reg(uer_pkg::REG_PULSE, {8'h00, pulse});
		write_reg(uer_pkg::REG_SETTLE, {8'h00, settle});
		write_reg(uer_pkg::REG_GAP, gap);
		cfg_ch.valid <= 1'b0;
	endtask

	// short random timings so many measurements finish per setting
	task automatic random_timing();
		logic [15:0] tmo;
		case ($urandom_range(0, 7))
			0:       tmo = 16'd1;
			1:       tmo = 16'($urandom_range(58, 700));
			default: tmo = 16'($urandom_range(1, 200));
		endcase
		set_timing(tmo, ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(1, 6)),
			($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 4)),
			16'($urandom_range(0, 8)));
	endtask

	task automatic plan_echo(int low_ticks, int high_ticks);
		rise_wait = low_ticks;
		high_left = high_ticks;
		armed = 1'b1;
	endtask

	// Echo levels for the next tick. Bits of sensors not being measured are noise.
	// A fresh random plan is drawn for each measurement unless one was set up front.
	function logic [3:0] pick_echo();
		logic [3:0] e;
		int t;
		e = 4'($urandom);
		t = int'(sb.timeout_us);
		if (sb.phase == RG_GAP) begin
			armed = 1'b0;
		end else if (sb.phase == RG_RISE || sb.phase == RG_HIGH) begin
			if (!armed) begin
				armed = 1'b1;
				case ($urandom_range(0, 9))
					0:       rise_wait = t + $urandom_range(1, 4);   // never rises in time
					1:       rise_wait = t;                          // rises on the last allowed tick
					default: rise_wait = $urandom_range(0, (t < 12) ? t : 12);
				endcase
				case ($urandom_range(0, 9))
					0, 1:    high_left = t + $urandom_range(1, 4);   // echo too long
					2:       high_left = t;                          // longest accepted echo
					default: high_left = $urandom_range(0, (t < 400) ? t : 400);
				endcase
			end
			if (rise_wait > 0) begin
				e[sb.sensor] = 1'b0;
				rise_wait--;
			end else if (high_left > 0) begin
				e[sb.sensor] = 1'b1;
				high_left--;
			end else begin
				e[sb.sensor] = 1'b0;
			end
			if (glitches && $urandom_range(0, 39) == 0)
				e[sb.sensor] = ~e[sb.sensor];
		end
		return e;
	endfunction

	// plain ticks until the block is idle; now and then a request that must be ignored
	task automatic run_until_idle();
		uer_pkg::action_t act;
		while (sb.phase != RG_IDLE) begin
			act = ($urandom_range(0, 15) == 0) ? uer_pkg::action_t'($urandom_range(0, 3)) :
				uer_pkg::ACT_TICK;
			offer_tick(act, 3'($urandom), pick_echo());
		end
	endtask

	// one random tick: requests, bad indexes and the spare code while idle, mostly plain ticks while busy
	task automatic random_tick();
		uer_pkg::action_t act;
		logic [2:0] idx;
		idx = 3'($urandom);
		act = uer_pkg::ACT_TICK;
		if (sb.phase == RG_IDLE) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					act = uer_pkg::ACT_MEASURE;
					idx = 3'($urandom_range(0, 3));
				end
				4: begin
					act = uer_pkg::ACT_MEASURE;
					idx = 3'($urandom_range(4, 7));
				end
				5, 6, 7: act = uer_pkg::ACT_SWEEP;
				8:       act = ACT_SPARE;
				default: act = uer_pkg::ACT_TICK;
			endcase
		end else if ($urandom_range(0, 9) == 0) begin
			act = uer_pkg::action_t'($urandom_range(0, 3));
		end
		offer_tick(act, idx, pick_echo());
	endtask

	// ---------------------------------------------------------------- stimulus
	initial begin
		int phase_len;
		tick_ch.valid <= 1'b0;
		tick_ch.action <= uer_pkg::ACT_TICK;
		tick_ch.sensor_index <= '0;
		tick_ch.echo_lines <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= uer_pkg::REG_TIMEOUT;
		cfg_ch.data <= '0;
		no_idle = 1'b0;
		hold_asks = 0;
		glitches = 1'b0;
		armed = 1'b0;
		rise_wait = 0;
		high_left = 0;
		ticks_random = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// -- reset timing: plain ticks, the spare action code, every bad index
		offer_tick(uer_pkg::ACT_TICK, 3'd0, 4'h0);
		offer_tick(ACT_SPARE, 3'd7, 4'hF);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd4, 4'h5);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd5, 4'hA);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd6, 4'h3);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd7, 4'hC);

		// one full measurement at reset timing, ~2 cm, then part of the 10000-tick gap
		plan_echo(5, 120);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd2, 4'h0);
		offer_tick(uer_pkg::ACT_SWEEP, 3'd0, pick_echo());     // busy: ignored
		offer_tick(uer_pkg::ACT_MEASURE, 3'd6, pick_echo());   // busy: no bad-index report
		hold_asks++;
		while (sb.phase != RG_GAP)
			offer_tick(uer_pkg::ACT_TICK, 3'($urandom), pick_echo());
		repeat (30) offer_tick(uer_pkg::ACT_TICK, 3'($urandom), pick_echo());
		// cut the running gap short; the new length applies at once
		drain();
		set_timing(uer_pkg::TIMEOUT_RST, uer_pkg::PULSE_RST, uer_pkg::SETTLE_RST, 16'd3);
		run_until_idle();
		drain();

		// -- zero timeout: a missing rise and a present echo both fail on the first tick
		set_timing(16'd0, 8'd1, 8'd0, 16'd0);
		plan_echo(1, 0);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd0, 4'h0);
		run_until_idle();
		plan_echo(0, 5);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd1, 4'hF);
		run_until_idle();
		offer_tick(uer_pkg::ACT_SWEEP, 3'd3, 4'h0);
		run_until_idle();
		drain();

		// -- widest timing: longest settle and pulse, widest timeout and gap
		set_timing(16'hFFFF, 8'd255, 8'd255, 16'hFFFF);
		plan_echo(3, 120);
		offer_tick(uer_pkg::ACT_MEASURE, 3'd3, 4'h0);
		while (sb.phase != RG_GAP)
			offer_tick(uer_pkg::ACT_TICK, 3'($urandom), pick_echo());
		repeat (20) offer_tick(uer_pkg::ACT_TICK, 3'($urandom), pick_echo());
		// shorten the guard gap while it is running; it applies at once
		drain();
		set_timing(16'hFFFF, 8'd255, 8'd255, 16'd3);
		run_until_idle();
		drain();

		// -- random part: short timings, a new setting after each pause
		glitches = 1'b1;
		while (ticks_random < 300) begin
			random_timing();
			phase_len = $urandom_range(40, 120);
			for (int k = 0; k < phase_len; k++) begin
				if (ticks_random == 100)
					hold_asks++;
				random_tick();
				ticks_random++;
			end
			drain();
		end

		// -- last part: one setting, both sides at full rate
		random_timing();
		no_idle = 1'b1;
		for (int k = 0; k < 100; k++) begin
			random_tick();
			ticks_random++;
		end

		// -- wind-down: nothing owed, then a short wait for a stray result to show
		drain();
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("PASS ultrasonic_echo_ranger");
		end else begin
			if (sb.owed.size() != 0)
				$display("%0t  results outstanding: expected 0 actual %0d", $time,
					sb.owed.size());
			$display("FAIL ultrasonic_echo_ranger");
		end
		$finish;
	end

endmodule
